// ===== rtl/slte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slte_pkg
// Shared types, constants and helper functions for the sprite list tile
// expander: register indexes, the configuration bundle, the decoded sprite
// descriptor and the sequencer state encoding.
// ----------------------------------------------------------------------------
package slte_pkg;

    // Largest number of cells kept along either axis of a sprite.
    localparam int MAX_CELLS = 8;
    localparam int CELL_W    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    // Field widths.
    localparam int WORD_W   = 16;
    localparam int OFS_W    = 10;
    localparam int PAL_W    = 11;
    localparam int MAP_W    = 17;
    localparam int CODE_W   = 18;
    localparam int POS_W    = 12;
    localparam int ZOOM_W   = 6;
    localparam int PMASK_W  = 8;
    localparam int ORG_W    = 9;
    localparam int COL_W    = 6;
    // Accumulated cell index times zoom step, (MAX_CELLS - 1) * 32 at most.
    localparam int ACC_W    = CELL_W + ZOOM_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_BASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_COLOUR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_MASK       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_DRAW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRI_FILTER     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_PRI       = 3'd7;

    localparam logic [MAP_W-1:0] MAP_MASK_RESET = 17'h07fff;

    // Priority filter modes.
    localparam logic [1:0] FILT_NONE  = 2'd0;
    localparam logic [1:0] FILT_RAW   = 2'd1;
    localparam logic [1:0] FILT_UPPER = 2'd2;

    // Pixel priority masks.
    localparam logic [PMASK_W-1:0] PMASK_PRI0 = 8'h00;
    localparam logic [PMASK_W-1:0] PMASK_PRI1 = 8'hf0;
    localparam logic [PMASK_W-1:0] PMASK_PRI2 = 8'hfc;
    localparam logic [PMASK_W-1:0] PMASK_PRI3 = 8'hfe;

    // Zoom step base: step = 32 - zoom nibble.
    localparam logic [ZOOM_W-1:0] ZOOM_BASE = 6'd32;

    // Configuration register bundle.
    typedef struct packed {
        logic [OFS_W-1:0]   x_offset;
        logic [OFS_W-1:0]   y_offset;
        logic [OFS_W-1:0]   palette_base;
        logic               wide_colour;
        logic [MAP_W-1:0]   map_mask;
        logic               priority_draw;
        logic [1:0]         pri_filter_mode;
        logic [1:0]         draw_pri;
    } cfg_t;

    // Decoded sprite, handed from the decoder to the tile sequencer.
    typedef struct packed {
        logic                       draw;
        logic signed [POS_W-1:0]    ox;
        logic signed [POS_W-1:0]    oy;
        logic [CELL_W-1:0]          cols_m1;
        logic [CELL_W-1:0]          rows_m1;
        logic [ZOOM_W-1:0]          zx;
        logic [ZOOM_W-1:0]          zy;
        logic                       fx;
        logic                       fy;
        logic [PAL_W-1:0]           palette;
        logic [PMASK_W-1:0]         pmask;
        logic [MAP_W-1:0]           map;
        logic [ACC_W-1:0]           x_start;
        logic [ACC_W-1:0]           y_start;
    } sprite_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } seq_state_t;

    // Cell count minus one, saturated so that at most MAX_CELLS cells remain.
    function automatic logic [CELL_W-1:0] cell_m1(input logic [2:0] size_field);
        logic [3:0] lim;
        lim = 4'(MAX_CELLS - 1);
        if ({1'b0, size_field} > lim)
            return CELL_W'(lim);
        else
            return CELL_W'(size_field);
    endfunction

    // Pixel priority mask for an effective priority level.
    function automatic logic [PMASK_W-1:0] pri_mask(input logic [1:0] pri);
        logic [PMASK_W-1:0] m;
        case (pri)
            2'd1:    m = PMASK_PRI1;
            2'd2:    m = PMASK_PRI2;
            2'd3:    m = PMASK_PRI3;
            default: m = PMASK_PRI0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/slte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slte_in_if / slte_out_if
// Valid/ready channels of the expander: the sprite entry beat on the input
// side and the tile command beat on the output side.
// ----------------------------------------------------------------------------
interface slte_in_if;
    logic                               valid;
    logic                               ready;
    logic                               frame_start;
    logic [slte_pkg::WORD_W-1:0]        list_word;
    logic [slte_pkg::WORD_W-1:0]        attr_word0;
    logic [slte_pkg::WORD_W-1:0]        attr_word1;
    logic [slte_pkg::WORD_W-1:0]        attr_word2;
    logic [slte_pkg::WORD_W-1:0]        attr_word3;

    modport source (
        output valid, frame_start, list_word, attr_word0, attr_word1,
               attr_word2, attr_word3,
        input  ready
    );
    modport sink (
        input  valid, frame_start, list_word, attr_word0, attr_word1,
               attr_word2, attr_word3,
        output ready
    );
endinterface

interface slte_out_if;
    logic                               valid;
    logic                               ready;
    logic [slte_pkg::CODE_W-1:0]        tile_code;
    logic signed [slte_pkg::POS_W-1:0]  x_pos;
    logic signed [slte_pkg::POS_W-1:0]  y_pos;
    logic [slte_pkg::PAL_W-1:0]         palette;
    logic                               flip_x;
    logic                               flip_y;
    logic [slte_pkg::ZOOM_W-1:0]        zoom_x;
    logic [slte_pkg::ZOOM_W-1:0]        zoom_y;
    logic [slte_pkg::PMASK_W-1:0]       pixel_mask;
    logic                               last_tile;

    modport source (
        output valid, tile_code, x_pos, y_pos, palette, flip_x, flip_y,
               zoom_x, zoom_y, pixel_mask, last_tile,
        input  ready
    );
    modport sink (
        input  valid, tile_code, x_pos, y_pos, palette, flip_x, flip_y,
               zoom_x, zoom_y, pixel_mask, last_tile,
        output ready
    );
endinterface

// ===== rtl/slte_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slte_decode
// Decodes one sorting-list entry and its attribute words into a sprite
// descriptor: origin, cell counts, zoom steps, flips, palette, priority mask,
// map start and the starting offsets for flipped traversal.
// ----------------------------------------------------------------------------
module slte_decode (
    input  slte_pkg::cfg_t                  cfg,
    input  logic                            ended,
    input  logic [slte_pkg::WORD_W-1:0]     list_word,
    input  logic [slte_pkg::WORD_W-1:0]     attr_word0,
    input  logic [slte_pkg::WORD_W-1:0]     attr_word1,
    input  logic [slte_pkg::WORD_W-1:0]     attr_word2,
    input  logic [slte_pkg::WORD_W-1:0]     attr_word3,
    output logic                            end_mark,
    output slte_pkg::sprite_t               sprite
);

    logic [1:0]                         pri_raw;
    logic [1:0]                         pri_eff;
    logic                               pri_pass;
    logic [slte_pkg::COL_W-1:0]         colour;
    logic [slte_pkg::ZOOM_W-1:0]        zx;
    logic [slte_pkg::ZOOM_W-1:0]        zy;
    logic [slte_pkg::CELL_W-1:0]        cols_m1;
    logic [slte_pkg::CELL_W-1:0]        rows_m1;

    // The end mark is tested before the skip bit.
    assign end_mark = !ended && list_word[14];

    // Priority filter and the effective priority level.
    assign pri_raw = attr_word2[13:12];
    always_comb
    begin
        case (cfg.pri_filter_mode)
            slte_pkg::FILT_RAW:
            begin
                pri_eff  = pri_raw;
                pri_pass = (pri_raw == cfg.draw_pri);
            end
            slte_pkg::FILT_UPPER:
            begin
                pri_eff  = {1'b0, pri_raw[1]};
                pri_pass = ({1'b0, pri_raw[1]} == cfg.draw_pri);
            end
            default:
            begin
                pri_eff  = pri_raw;
                pri_pass = 1'b1;
            end
        endcase
    end

    // Color keeps five or six bits.
    assign colour = cfg.wide_colour ? attr_word2[13:8] : {1'b0, attr_word2[12:8]};

    assign zy      = slte_pkg::ZOOM_BASE - slte_pkg::ZOOM_W'(attr_word0[15:12]);
    assign zx      = slte_pkg::ZOOM_BASE - slte_pkg::ZOOM_W'(attr_word1[15:12]);
    assign rows_m1 = slte_pkg::cell_m1(attr_word0[11:9]);
    assign cols_m1 = slte_pkg::cell_m1(attr_word1[11:9]);

    // Descriptor fields.
    always_comb
    begin
        sprite.draw    = !ended && !list_word[14] && !list_word[15] && pri_pass;
        sprite.oy      = signed'(slte_pkg::POS_W'(attr_word0[8:0]))
                       + slte_pkg::POS_W'(signed'(cfg.y_offset));
        sprite.ox      = signed'(slte_pkg::POS_W'(attr_word1[8:0]))
                       + slte_pkg::POS_W'(signed'(cfg.x_offset));
        sprite.cols_m1 = cols_m1;
        sprite.rows_m1 = rows_m1;
        sprite.zx      = zx;
        sprite.zy      = zy;
        sprite.fx      = attr_word2[14];
        sprite.fy      = attr_word2[15];
        sprite.palette = slte_pkg::PAL_W'(colour) + slte_pkg::PAL_W'(cfg.palette_base);
        sprite.pmask   = cfg.priority_draw ? slte_pkg::pri_mask(pri_eff)
                                           : slte_pkg::PMASK_PRI0;
        sprite.map     = {attr_word2[0], attr_word3} & cfg.map_mask;
        // A flipped axis starts at the last kept cell and walks back.
        sprite.x_start = attr_word2[14]
                       ? slte_pkg::ACC_W'(slte_pkg::ACC_W'(cols_m1) * slte_pkg::ACC_W'(zx))
                       : '0;
        sprite.y_start = attr_word2[15]
                       ? slte_pkg::ACC_W'(slte_pkg::ACC_W'(rows_m1) * slte_pkg::ACC_W'(zy))
                       : '0;
    end

endmodule

// ===== rtl/slte_tile_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slte_tile_seq
// Tile sequencer: walks the cells of one sprite row by row, one tile command
// per cycle, stepping the column or row offset through one shared add/subtract
// unit; each command waits in an output register, stalling the walk, until taken.
// ----------------------------------------------------------------------------
module slte_tile_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  slte_pkg::sprite_t   sprite,
    output logic                busy,
    slte_out_if.source          tile_out
);

    slte_pkg::seq_state_t               state_reg, state_next;
    slte_pkg::sprite_t                  spr_reg;
    logic [slte_pkg::CELL_W-1:0]        col_reg, col_next;
    logic [slte_pkg::CELL_W-1:0]        row_reg, row_next;
    logic [slte_pkg::ACC_W-1:0]         x_acc_reg, x_acc_next;
    logic [slte_pkg::ACC_W-1:0]         y_acc_reg, y_acc_next;
    logic [slte_pkg::CODE_W-1:0]        code_reg, code_next;
    logic                               out_valid_reg;

    logic                               out_load;
    logic                               emit;
    logic                               row_end;
    logic                               at_last;
    logic [slte_pkg::ACC_W-1:0]         alu_a;
    logic [slte_pkg::ACC_W-1:0]         alu_b;
    logic                               alu_sub;
    logic [slte_pkg::ACC_W-1:0]         alu_y;

    assign busy     = (state_reg == slte_pkg::ST_RUN);
    assign out_load = !out_valid_reg || tile_out.ready;
    assign emit     = busy && out_load;
    assign row_end  = (col_reg == spr_reg.cols_m1);
    assign at_last  = row_end && (row_reg == spr_reg.rows_m1);

    // Shared step unit: the column offset within a row, the row offset at its end.
    assign alu_a   = row_end ? y_acc_reg : x_acc_reg;
    assign alu_b   = slte_pkg::ACC_W'(row_end ? spr_reg.zy : spr_reg.zx);
    assign alu_sub = row_end ? spr_reg.fy : spr_reg.fx;
    assign alu_y   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    // Next-state logic of the cell walk.
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        x_acc_next = x_acc_reg;
        y_acc_next = y_acc_reg;
        code_next  = code_reg;
        case (state_reg)
            slte_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = slte_pkg::ST_RUN;
                    col_next   = '0;
                    row_next   = '0;
                    x_acc_next = sprite.x_start;
                    y_acc_next = sprite.y_start;
                    code_next  = slte_pkg::CODE_W'(sprite.map);
                end
            end
            slte_pkg::ST_RUN:
            begin
                if (emit)
                begin
                    code_next = code_reg + slte_pkg::CODE_W'(1);
                    if (at_last)
                    begin
                        state_next = slte_pkg::ST_IDLE;
                    end
                    else if (row_end)
                    begin
                        col_next   = '0;
                        row_next   = row_reg + slte_pkg::CELL_W'(1);
                        x_acc_next = spr_reg.x_start;
                        y_acc_next = alu_y;
                    end
                    else
                    begin
                        col_next   = col_reg + slte_pkg::CELL_W'(1);
                        x_acc_next = alu_y;
                    end
                end
            end
            default:
            begin
                state_next = slte_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slte_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= emit;
        end
    end

    // Walk counters and the latched sprite descriptor.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            spr_reg <= sprite;
        col_reg   <= col_next;
        row_reg   <= row_next;
        x_acc_reg <= x_acc_next;
        y_acc_reg <= y_acc_next;
        code_reg  <= code_next;
    end

    // Output register: one tile command beat.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            tile_out.tile_code  <= code_reg;
            tile_out.x_pos      <= spr_reg.ox
                                 + signed'(slte_pkg::POS_W'(x_acc_reg[slte_pkg::ACC_W-1:1]));
            tile_out.y_pos      <= spr_reg.oy
                                 + signed'(slte_pkg::POS_W'(y_acc_reg[slte_pkg::ACC_W-1:1]));
            tile_out.palette    <= spr_reg.palette;
            tile_out.flip_x     <= spr_reg.fx;
            tile_out.flip_y     <= spr_reg.fy;
            tile_out.zoom_x     <= spr_reg.zx;
            tile_out.zoom_y     <= spr_reg.zy;
            tile_out.pixel_mask <= spr_reg.pmask;
            tile_out.last_tile  <= at_last;
        end
    end

    assign tile_out.valid = out_valid_reg;

endmodule

// ===== rtl/sprite_list_tile_expander.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_list_tile_expander
// Expands sorting-list sprite entries into one tile command per cell, with
// end-of-list and skip handling, an optional priority filter and flip-ordered
// traversal.
//
//   Channel   Direction  Handshake           Beat carries
//   item_in   in         valid / ready       frame_start, list word, 4 attributes
//   tile_out  out        valid / ready       one tile command
//   cfg       in         cfg_we (no ready)   register index and write data
//
// An entry is decoded combinationally as it is accepted; the cell walk sequencer
// then issues one tile per cycle. An entry that draws nothing starts no walk.
// Up to 64 tiles per sprite. A stalled output register holds the walk, and
// item_in.ready is low while the walk runs. Reset sets the registers to their
// defaults and clears the end-of-list mark.
// ----------------------------------------------------------------------------
module sprite_list_tile_expander (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [slte_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [slte_pkg::CFG_DATA_W-1:0]     cfg_data,
    slte_in_if.sink                             item_in,
    slte_out_if.source                          tile_out
);

    slte_pkg::cfg_t         cfg_reg;
    logic                   list_ended_reg;
    logic                   ended;
    logic                   end_mark;
    logic                   accept;
    logic                   busy;
    slte_pkg::sprite_t      sprite;

    assign item_in.ready = !busy;
    assign accept        = item_in.valid && item_in.ready;

    // The frame-start bit clears the end mark before this entry is tested.
    assign ended = list_ended_reg && !item_in.frame_start;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_offset        <= '0;
            cfg_reg.y_offset        <= '0;
            cfg_reg.palette_base    <= '0;
            cfg_reg.wide_colour     <= 1'b0;
            cfg_reg.map_mask        <= slte_pkg::MAP_MASK_RESET;
            cfg_reg.priority_draw   <= 1'b0;
            cfg_reg.pri_filter_mode <= slte_pkg::FILT_NONE;
            cfg_reg.draw_pri        <= 2'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                slte_pkg::REG_X_OFFSET:      cfg_reg.x_offset        <= cfg_data[9:0];
                slte_pkg::REG_Y_OFFSET:      cfg_reg.y_offset        <= cfg_data[9:0];
                slte_pkg::REG_PALETTE_BASE:  cfg_reg.palette_base    <= cfg_data[9:0];
                slte_pkg::REG_WIDE_COLOUR:   cfg_reg.wide_colour     <= cfg_data[0];
                slte_pkg::REG_MAP_MASK:      cfg_reg.map_mask        <= cfg_data;
                slte_pkg::REG_PRIORITY_DRAW: cfg_reg.priority_draw   <= cfg_data[0];
                slte_pkg::REG_PRI_FILTER:    cfg_reg.pri_filter_mode <= cfg_data[1:0];
                slte_pkg::REG_DRAW_PRI:      cfg_reg.draw_pri        <= cfg_data[1:0];
                default:                     cfg_reg.draw_pri        <= cfg_reg.draw_pri;
            endcase
        end
    end

    // End-of-list mark, updated on every accepted entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            list_ended_reg <= 1'b0;
        else if (accept)
            list_ended_reg <= ended || end_mark;
    end

    slte_decode u_decode (
        .cfg        (cfg_reg),
        .ended      (ended),
        .list_word  (item_in.list_word),
        .attr_word0 (item_in.attr_word0),
        .attr_word1 (item_in.attr_word1),
        .attr_word2 (item_in.attr_word2),
        .attr_word3 (item_in.attr_word3),
        .end_mark   (end_mark),
        .sprite     (sprite)
    );

    slte_tile_seq u_tile_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && sprite.draw),
        .sprite   (sprite),
        .busy     (busy),
        .tile_out (tile_out)
    );

endmodule

// ===== dv/tb_sprite_list_tile_expander.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_list_tile_expander
// Self-checking bench for the sprite list tile expander. Sprite entries are
// fed through the input channel while a tile tracker works out the tile
// commands each accepted beat must produce. Every tile command taken from
// the output channel is compared field by field with the oldest one still
// owed. Directed entries cover the extremes and the end, skip and flip
// cases. Random frames follow under several register settings, with
// sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_sprite_list_tile_expander;
    import slte_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 80;
    localparam int MAX_REPORTS   = 10;

    // Filter mode code that the package leaves unnamed; it behaves as no filter.
    localparam logic [1:0] FILT_SPARE = 2'd3;

    // List word flags.
    localparam logic [WORD_W-1:0] LW_END  = 16'h4000;
    localparam logic [WORD_W-1:0] LW_SKIP = 16'h8000;

    typedef struct packed {
        logic              frame_start;
        logic [WORD_W-1:0] list_word;
        logic [WORD_W-1:0] attr0;
        logic [WORD_W-1:0] attr1;
        logic [WORD_W-1:0] attr2;
        logic [WORD_W-1:0] attr3;
    } sprite_entry_t;

    typedef struct packed {
        logic [CODE_W-1:0]       tile_code;
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
        logic [PAL_W-1:0]        palette;
        logic                    flip_x;
        logic                    flip_y;
        logic [ZOOM_W-1:0]       zoom_x;
        logic [ZOOM_W-1:0]       zoom_y;
        logic [PMASK_W-1:0]      pixel_mask;
        logic                    last_tile;
    } tile_cmd_t;

    // Tracks the register copy and the end-of-list mark, expands accepted
    // entries into owed tile commands and checks the ones that come out.
    class tile_tracker;
        cfg_t      cfg;
        bit        list_ended;
        tile_cmd_t pending_tiles[$];
        int        fail_count;

        function new();
            cfg          = '0;
            cfg.map_mask = MAP_MASK_RESET;
            list_ended   = 1'b0;
            fail_count   = 0;
        endfunction

        function void note_failure(string msg);
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function string describe(tile_cmd_t t);
            return $sformatf({"code=%05h x=%0d y=%0d pal=%0d fx=%0b fy=%0b ",
                              "zx=%0d zy=%0d pmask=%02h last=%0b"},
                             t.tile_code, t.x_pos, t.y_pos, t.palette, t.flip_x,
                             t.flip_y, t.zoom_x, t.zoom_y, t.pixel_mask,
                             t.last_tile);
        endfunction

        // Works out the tile commands one accepted entry owes.
        function void expand_entry(sprite_entry_t e);
            int                 ox;
            int                 oy;
            int                 rows;
            int                 cols;
            int                 zx;
            int                 zy;
            int                 xc;
            int                 yc;
            int                 k;
            int                 total;
            logic [5:0]         colour;
            logic [1:0]         pri;
            logic [MAP_W-1:0]   map;
            logic [PAL_W-1:0]   pal;
            logic [PMASK_W-1:0] pmask;
            tile_cmd_t          t;

            // End of list is tested before skip, after frame start clears it.
            if (e.frame_start)
                list_ended = 1'b0;
            if (list_ended)
                return;
            if ((e.list_word & LW_END) != '0)
            begin
                list_ended = 1'b1;
                return;
            end
            if ((e.list_word & LW_SKIP) != '0)
                return;

            oy   = int'(e.attr0[8:0]) + int'($signed(cfg.y_offset));
            ox   = int'(e.attr1[8:0]) + int'($signed(cfg.x_offset));
            rows = int'(e.attr0[11:9]) + 1;
            cols = int'(e.attr1[11:9]) + 1;
            if (rows > MAX_CELLS)
                rows = MAX_CELLS;
            if (cols > MAX_CELLS)
                cols = MAX_CELLS;
            zy = int'(ZOOM_BASE) - int'(e.attr0[15:12]);
            zx = int'(ZOOM_BASE) - int'(e.attr1[15:12]);

            colour = e.attr2[13:8];
            if (!cfg.wide_colour)
                colour[5] = 1'b0;
            pri = e.attr2[13:12];

            // Priority filter; the upper-bit mode also narrows the priority.
            case (cfg.pri_filter_mode)
                FILT_RAW:
                begin
                    if (pri != cfg.draw_pri)
                        return;
                end
                FILT_UPPER:
                begin
                    pri = pri >> 1;
                    if (pri != cfg.draw_pri)
                        return;
                end
                default: ;
            endcase

            pmask = PMASK_PRI0;
            if (cfg.priority_draw)
            begin
                case (pri)
                    2'd1:    pmask = PMASK_PRI1;
                    2'd2:    pmask = PMASK_PRI2;
                    2'd3:    pmask = PMASK_PRI3;
                    default: pmask = PMASK_PRI0;
                endcase
            end

            map   = {e.attr2[0], e.attr3} & cfg.map_mask;
            pal   = PAL_W'(colour) + PAL_W'(cfg.palette_base);
            total = rows * cols;
            k     = 0;

            // Rows in vertical flip order, cells in horizontal flip order.
            for (int r = 0; r < rows; r++)
            begin
                yc = e.attr2[15] ? rows - 1 - r : r;
                for (int c = 0; c < cols; c++)
                begin
                    xc = e.attr2[14] ? cols - 1 - c : c;
                    t.tile_code  = CODE_W'(map) + CODE_W'(k);
                    t.x_pos      = POS_W'(ox + (xc * zx) / 2);
                    t.y_pos      = POS_W'(oy + (yc * zy) / 2);
                    t.palette    = pal;
                    t.flip_x     = e.attr2[14];
                    t.flip_y     = e.attr2[15];
                    t.zoom_x     = ZOOM_W'(zx);
                    t.zoom_y     = ZOOM_W'(zy);
                    t.pixel_mask = pmask;
                    t.last_tile  = (k + 1 == total);
                    pending_tiles.push_back(t);
                    k++;
                end
            end
        endfunction

        // Compares one tile command from the block with the oldest owed one.
        function void check_tile(tile_cmd_t got);
            tile_cmd_t want;
            bit        bad;

            if (pending_tiles.size() == 0)
            begin
                note_failure($sformatf("unexpected tile command: %s", describe(got)));
                return;
            end
            want = pending_tiles.pop_front();
            bad  = (got.tile_code  !== want.tile_code)  ||
                   (got.x_pos      !== want.x_pos)      ||
                   (got.y_pos      !== want.y_pos)      ||
                   (got.palette    !== want.palette)    ||
                   (got.flip_x     !== want.flip_x)     ||
                   (got.flip_y     !== want.flip_y)     ||
                   (got.zoom_x     !== want.zoom_x)     ||
                   (got.zoom_y     !== want.zoom_y)     ||
                   (got.pixel_mask !== want.pixel_mask) ||
                   (got.last_tile  !== want.last_tile);
            if (bad)
                note_failure($sformatf("tile mismatch: expected %s / got %s",
                                       describe(want), describe(got)));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    slte_in_if  in_ch ();
    slte_out_if out_ch ();

    tile_tracker tracker;

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int ready_hold_left = 0;
    int cycle_count     = 0;

    sprite_list_tile_expander dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_in   (in_ch),
        .tile_out  (out_ch)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit.
    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin : tile_receiver
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                ready_hold_left--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Output monitor: every accepted tile beat goes to the tracker.
    initial
    begin : tile_monitor
        tile_cmd_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got.tile_code  = out_ch.tile_code;
                got.x_pos      = out_ch.x_pos;
                got.y_pos      = out_ch.y_pos;
                got.palette    = out_ch.palette;
                got.flip_x     = out_ch.flip_x;
                got.flip_y     = out_ch.flip_y;
                got.zoom_x     = out_ch.zoom_x;
                got.zoom_y     = out_ch.zoom_y;
                got.pixel_mask = out_ch.pixel_mask;
                got.last_tile  = out_ch.last_tile;
                tracker.check_tile(got);
            end
        end
    end

    function automatic sprite_entry_t mk_entry(logic fs, logic [WORD_W-1:0] lw,
                                               logic [WORD_W-1:0] w0,
                                               logic [WORD_W-1:0] w1,
                                               logic [WORD_W-1:0] w2,
                                               logic [WORD_W-1:0] w3);
        sprite_entry_t e;
        e.frame_start = fs;
        e.list_word   = lw;
        e.attr0       = w0;
        e.attr1       = w1;
        e.attr2       = w2;
        e.attr3       = w3;
        return e;
    endfunction

    function automatic sprite_entry_t random_entry(logic fs, logic [WORD_W-1:0] lw);
        return mk_entry(fs, lw, WORD_W'($urandom), WORD_W'($urandom),
                        WORD_W'($urandom), WORD_W'($urandom));
    endfunction

    function automatic cfg_t random_setting(logic [1:0] mode);
        cfg_t s;
        s.x_offset        = OFS_W'($urandom);
        s.y_offset        = OFS_W'($urandom);
        s.palette_base    = OFS_W'($urandom);
        s.wide_colour     = 1'($urandom);
        s.map_mask        = MAP_W'($urandom);
        s.priority_draw   = 1'($urandom);
        s.pri_filter_mode = mode;
        s.draw_pri        = 2'($urandom_range(3));
        return s;
    endfunction

    // Offers one entry beat, after a random gap, and waits for acceptance.
    task automatic drive_entry(sprite_entry_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.frame_start <= e.frame_start;
        in_ch.list_word   <= e.list_word;
        in_ch.attr_word0  <= e.attr0;
        in_ch.attr_word1  <= e.attr1;
        in_ch.attr_word2  <= e.attr2;
        in_ch.attr_word3  <= e.attr3;
        do
            @(posedge clk);
        while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        tracker.expand_entry(e);
    endtask

    // Stops offering until every owed tile has come, then lets the block settle.
    task automatic drain_tiles();
        in_ch.valid <= 1'b0;
        while (tracker.pending_tiles.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all eight registers, one per cycle, from a setting bundle.
    task automatic apply_setting(cfg_t s);
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        for (int i = 0; i < 8; i++)
        begin
            idx = CFG_IDX_W'(i);
            case (idx)
                REG_X_OFFSET:      data = CFG_DATA_W'(s.x_offset);
                REG_Y_OFFSET:      data = CFG_DATA_W'(s.y_offset);
                REG_PALETTE_BASE:  data = CFG_DATA_W'(s.palette_base);
                REG_WIDE_COLOUR:   data = CFG_DATA_W'(s.wide_colour);
                REG_MAP_MASK:      data = CFG_DATA_W'(s.map_mask);
                REG_PRIORITY_DRAW: data = CFG_DATA_W'(s.priority_draw);
                REG_PRI_FILTER:    data = CFG_DATA_W'(s.pri_filter_mode);
                REG_DRAW_PRI:      data = CFG_DATA_W'(s.draw_pri);
                default:           data = '0;
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        tracker.cfg = s;
    endtask

    // Random frames: a frame start, live entries with some skips, usually an
    // end-of-list entry followed by a little ignored noise.
    task automatic run_random_phase(cfg_t s, int idle_pct, int stall_pct,
                                    int drawn_goal, bit mid_drain, bit long_hold);
        sprite_entry_t     e;
        logic [WORD_W-1:0] lw;
        int                drawn;
        int                n;
        bit                drained;
        bit                held;

        drain_tiles();
        apply_setting(s);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        drawn          = 0;
        drained        = 1'b0;
        held           = 1'b0;
        while (drawn < drawn_goal)
        begin
            n = $urandom_range(10, 3);
            for (int j = 0; j < n; j++)
            begin
                lw = WORD_W'($urandom) & ~(LW_END | LW_SKIP);
                if ($urandom_range(9) == 0)
                    lw = lw | LW_SKIP;
                e = random_entry((j == 0) || ($urandom_range(19) == 0), lw);
                drive_entry(e);
                if ((lw & LW_SKIP) == '0)
                    drawn++;
                if (long_hold && !held && drawn >= 4)
                begin
                    ready_hold_left = HOLD_CYCLES;
                    held = 1'b1;
                end
                if (mid_drain && !drained && drawn >= drawn_goal / 2)
                begin
                    drain_tiles();
                    drained = 1'b1;
                end
            end
            if ($urandom_range(9) < 7)
            begin
                drive_entry(random_entry(1'b0, WORD_W'($urandom) | LW_END));
                repeat ($urandom_range(2))
                    drive_entry(random_entry(1'b0, WORD_W'($urandom)));
            end
        end
    endtask

    // Main sequence.
    initial
    begin : stimulus
        cfg_t max_setting;
        cfg_t min_setting;
        cfg_t s;

        tracker = new();
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.frame_start <= 1'b0;
        in_ch.list_word   <= '0;
        in_ch.attr_word0  <= '0;
        in_ch.attr_word1  <= '0;
        in_ch.attr_word2  <= '0;
        in_ch.attr_word3  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        max_setting = '{x_offset: 10'h200, y_offset: 10'h1ff, palette_base: 10'h3ff,
                        wide_colour: 1'b1, map_mask: 17'h1ffff, priority_draw: 1'b1,
                        pri_filter_mode: FILT_NONE, draw_pri: 2'd3};
        min_setting = '{x_offset: 10'h1ff, y_offset: 10'h200, palette_base: 10'h000,
                        wide_colour: 1'b0, map_mask: 17'h00000, priority_draw: 1'b0,
                        pri_filter_mode: FILT_NONE, draw_pri: 2'd0};

        // Directed entries under the reset values of the registers.
        drive_entry(mk_entry(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        drive_entry(mk_entry(1'b0, 16'h3fff, 16'hffff, 16'hffff, 16'h3fff, 16'hffff));
        drive_entry(mk_entry(1'b0, 16'h0123, 16'h0405, 16'h0210, 16'h4500, 16'h1000));
        drive_entry(mk_entry(1'b0, 16'h0000, 16'h0600, 16'h0400, 16'h8000, 16'h0020));
        drive_entry(mk_entry(1'b0, 16'h0000, 16'h3400, 16'h9600, 16'hc0ff, 16'h7fff));
        // Skip, then end of list, then an entry that the ended list ignores.
        drive_entry(mk_entry(1'b0, LW_SKIP | 16'h03ff, 16'h0200, 16'h0200, 16'h0000,
                             16'h0001));
        drive_entry(mk_entry(1'b0, LW_END, 16'h0200, 16'h0200, 16'h0000, 16'h0002));
        drive_entry(mk_entry(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0003));
        // Frame start with end and skip together: the end wins.
        drive_entry(mk_entry(1'b1, LW_END | LW_SKIP, 16'h0000, 16'h0000, 16'h0000,
                             16'h0004));
        drive_entry(mk_entry(1'b0, LW_SKIP, 16'h0000, 16'h0000, 16'h0000, 16'h0005));
        drive_entry(mk_entry(1'b1, 16'h0000, 16'h0e00, 16'h0000, 16'h0000, 16'h0006));
        drive_entry(mk_entry(1'b0, 16'h0000, 16'hf000, 16'hf000, 16'h2a01, 16'hffff));

        // Directed entries under the widest setting: offsets at their ends.
        drain_tiles();
        apply_setting(max_setting);
        drive_entry(mk_entry(1'b1, 16'h0000, 16'h0000, 16'h0e00, 16'h4000, 16'h0000));
        drive_entry(mk_entry(1'b0, 16'h0000, 16'h0fff, 16'h01ff, 16'h3f00, 16'h0000));
        drive_entry(mk_entry(1'b0, 16'h0000, 16'h0200, 16'h0200, 16'h0500, 16'h0010));
        drive_entry(mk_entry(1'b0, 16'h0000, 16'h0200, 16'h0200, 16'h1a00, 16'h0020));
        drive_entry(mk_entry(1'b0, 16'h0000, 16'h0200, 16'h0200, 16'h2c00, 16'h0030));
        drive_entry(mk_entry(1'b0, 16'h0000, 16'h0200, 16'h0200, 16'h3100, 16'h0040));
        drive_entry(mk_entry(1'b0, 16'h0000, 16'hffff, 16'hffff, 16'hff01, 16'hffff));
        drive_entry(mk_entry(1'b0, LW_END, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

        // Random frames under changing settings and handshake pressure.
        run_random_phase(random_setting(FILT_RAW), 0, 0, 24, 1'b0, 1'b0);
        s = random_setting(FILT_UPPER);
        s.draw_pri = 2'($urandom_range(1));
        run_random_phase(s, 53, 0, 24, 1'b1, 1'b0);
        run_random_phase(random_setting(FILT_SPARE), 0, 53, 24, 1'b0, 1'b0);
        run_random_phase(min_setting, 0, 0, 24, 1'b0, 1'b1);
        // Upper-bit filter with a level it can never match.
        s = random_setting(FILT_UPPER);
        s.draw_pri = 2'd2;
        run_random_phase(s, 26, 26, 8, 1'b0, 1'b0);
        s = random_setting(2'($urandom_range(3)));
        s.priority_draw = 1'b1;
        run_random_phase(s, 26, 26, 24, 1'b0, 1'b0);

        // Let everything owed arrive, then watch for stray beats.
        drain_tiles();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.pending_tiles.size() != 0)
            tracker.note_failure($sformatf("%0d tile commands never arrived",
                                           tracker.pending_tiles.size()));
        if (tracker.fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/slte_pkg.sv
rtl/slte_if.sv
rtl/slte_decode.sv
rtl/slte_tile_seq.sv
rtl/sprite_list_tile_expander.sv
dv/tb_sprite_list_tile_expander.sv
